@@ sv/tsd_pkg.sv @@
package tsd_pkg;

  localparam logic [3:0] CMD_USEC    = 4'd0;
  localparam logic [3:0] CMD_SEC     = 4'd1;
  localparam logic [3:0] CMD_MIN     = 4'd2;
  localparam logic [3:0] CMD_HOUR    = 4'd3;
  localparam logic [3:0] CMD_DAY     = 4'd4;
  localparam logic [3:0] CMD_WEEK    = 4'd5;
  localparam logic [3:0] CMD_MONTH   = 4'd6;
  localparam logic [3:0] CMD_QUARTER = 4'd7;
  localparam logic [3:0] CMD_YEAR    = 4'd8;

  localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
  localparam logic [19:0] USEC_PER_SEC  = 20'd1000000;
  localparam logic [11:0] USEC_SEC_MAX  = 12'd2147;
  localparam logic [3:0]  MONTHS_PER_YR = 4'd12;

  // Reciprocal multipliers: x / N == (x * RECIP_N) >> SHIFT_N over the value
  // range that reaches each one.
  localparam logic [12:0] RECIP_100  = 13'd5243;
  localparam int          SHIFT_100  = 19;
  localparam logic [15:0] RECIP_25   = 16'd41944;
  localparam int          SHIFT_25   = 20;
  localparam logic [23:0] RECIP_7    = 24'd9586981;
  localparam int          SHIFT_7    = 26;
  localparam logic [16:0] RECIP_3600 = 17'd74566;
  localparam int          SHIFT_3600 = 28;
  localparam logic [18:0] RECIP_60   = 19'd279621;
  localparam int          SHIFT_60   = 24;
  localparam logic [18:0] RECIP_3    = 19'd349526;
  localparam int          SHIFT_3    = 20;

  typedef struct packed {
    logic [3:0]  cmd;
    logic [13:0] start_year;
    logic [3:0]  start_month;
    logic [4:0]  start_day;
    logic [16:0] start_time_of_day;
    logic [13:0] end_year;
    logic [3:0]  end_month;
    logic [4:0]  end_day;
    logic [16:0] end_time_of_day;
  } item_t;

  typedef struct packed {
    logic signed [31:0] difference;
    logic               saturated;
  } result_t;

  typedef struct packed {
    logic [22:0]        day_num;
    logic [16:0]        tod;
    logic signed [15:0] year;
    logic [3:0]         month;
    logic [4:0]         day;
  } stamp_t;

  typedef struct packed {
    logic [3:0]  cmd;
    logic        neg;
    logic [22:0] days;
    logic [16:0] secs;
    logic [17:0] months;
    logic [14:0] years;
  } span_t;

  function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    case (month) inside
      4'd2: len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

  // Days from March 1 to the first of the month, in a year that starts in March.
  function automatic logic [8:0] cum_days(input logic [3:0] month);
    logic [8:0] d;
    case (month)
      4'd1:    d = 9'd306;
      4'd2:    d = 9'd337;
      4'd3:    d = 9'd0;
      4'd4:    d = 9'd31;
      4'd5:    d = 9'd61;
      4'd6:    d = 9'd92;
      4'd7:    d = 9'd122;
      4'd8:    d = 9'd153;
      4'd9:    d = 9'd184;
      4'd10:   d = 9'd214;
      4'd11:   d = 9'd245;
      4'd12:   d = 9'd275;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

@@ sv/timestamp_difference_by_unit.sv @@
// Gives the signed difference, end minus start, between two date-times in the
// unit selected by cmd, with a saturation flag when it does not fit 32 bits.
// A transaction is taken at every clock edge where start is high; busy is
// always low, so a new pair can be started in every cycle. Each result comes
// out with done high for exactly one cycle, and results leave in the order
// the transactions came in. The receiver cannot stall the pipeline and must
// take each result as it appears. The pipeline consists of the input register,
// two stages of calendar normalization per date-time, two stages of difference
// and borrow, one stage of unit scaling multipliers and the result register.
module timestamp_difference_by_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  tsd_pkg::item_t    item,
  output logic              busy,
  output logic              done,
  output tsd_pkg::result_t  result
);

  tsd_pkg::item_t  item_q;
  logic            item_v;
  logic [3:0]      cmd_a;
  logic [3:0]      cmd_b;
  logic            v_a;
  logic            v_b;
  tsd_pkg::stamp_t stamp_a;
  tsd_pkg::stamp_t stamp_b;
  logic            span_v;
  tsd_pkg::span_t  span;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_v <= 1'b0;
      v_a    <= 1'b0;
      v_b    <= 1'b0;
    end else begin
      item_v <= start && !busy;
      v_a    <= item_v;
      v_b    <= v_a;
    end
  end

  always_ff @(posedge clk) begin
    item_q <= item;
    cmd_a  <= item_q.cmd;
    cmd_b  <= cmd_a;
  end

  tsd_stamp u_stamp_a (
    .clk         (clk),
    .year        (item_q.start_year),
    .month       (item_q.start_month),
    .day         (item_q.start_day),
    .time_of_day (item_q.start_time_of_day),
    .stamp       (stamp_a)
  );

  tsd_stamp u_stamp_b (
    .clk         (clk),
    .year        (item_q.end_year),
    .month       (item_q.end_month),
    .day         (item_q.end_day),
    .time_of_day (item_q.end_time_of_day),
    .stamp       (stamp_b)
  );

  tsd_span u_span (
    .clk      (clk),
    .rst      (rst),
    .valid_in (v_b),
    .cmd_in   (cmd_b),
    .stamp_a  (stamp_a),
    .stamp_b  (stamp_b),
    .valid    (span_v),
    .span     (span)
  );

  tsd_scale u_scale (
    .clk      (clk),
    .rst      (rst),
    .valid_in (span_v),
    .span     (span),
    .done     (done),
    .result   (result)
  );

endmodule

@@ sv/tsd_stamp.sv @@
module tsd_stamp (
  input  logic              clk,
  input  logic [13:0]       year,
  input  logic [3:0]        month,
  input  logic [4:0]        day,
  input  logic [16:0]       time_of_day,
  output tsd_pkg::stamp_t   stamp
);

  logic [3:0]         mm;
  logic signed [15:0] yy;
  logic [15:0]        yp_wide;
  logic [14:0]        yp;
  logic               carry;
  logic [16:0]        tod_n;
  logic signed [5:0]  dd;

  logic signed [15:0] a_yy;
  logic [3:0]         a_mm;
  logic signed [5:0]  a_dd;
  logic [16:0]        a_tod;
  logic [14:0]        a_yp;
  logic [22:0]        a_y365;
  logic [27:0]        a_p100;
  logic [30:0]        a_p25;

  logic [8:0]         q100;
  logic [10:0]        q25;
  logic               div25;
  logic               leap;
  logic [22:0]        base;
  logic [3:0]         prev_m;
  logic [3:0]         next_m;
  logic [4:0]         len_cur;
  logic [4:0]         len_prev;
  tsd_pkg::stamp_t    stamp_next;

  always_comb begin
    if (month == 4'd0) begin
      mm = 4'd12;
      yy = $signed({2'b00, year}) - 16'sd1;
    end else if (month > 4'd12) begin
      mm = month - 4'd12;
      yy = $signed({2'b00, year}) + 16'sd1;
    end else begin
      mm = month;
      yy = $signed({2'b00, year});
    end
  end

  // The year count starts in March, shifted by 400 years to stay positive.
  assign yp_wide = $unsigned(yy) + 16'd400 - {15'd0, (mm <= 4'd2)};
  assign yp      = yp_wide[14:0];
  assign carry   = time_of_day >= tsd_pkg::SECS_PER_DAY;
  assign tod_n   = carry ? time_of_day - tsd_pkg::SECS_PER_DAY : time_of_day;
  assign dd      = $signed({1'b0, day}) - 6'sd1 + $signed({5'd0, carry});

  always_ff @(posedge clk) begin
    a_yy   <= yy;
    a_mm   <= mm;
    a_dd   <= dd;
    a_tod  <= tod_n;
    a_yp   <= yp;
    a_y365 <= 23'(yp) * 23'd365;
    a_p100 <= 28'(yp) * 28'(tsd_pkg::RECIP_100);
    a_p25  <= 31'(yy[14:0]) * 31'(tsd_pkg::RECIP_25);
  end

  assign q100  = a_p100[tsd_pkg::SHIFT_100 +: 9];
  assign q25   = a_p25[tsd_pkg::SHIFT_25 +: 11];
  assign div25 = (15'(q25) * 15'd25) == a_yy[14:0];
  assign leap  = (a_yy[1:0] == 2'b00) && (!div25 || (a_yy[3:0] == 4'd0));

  assign base = a_y365 + {10'd0, a_yp[14:2]} - {14'd0, q100} + {16'd0, q100[8:2]}
              + {14'd0, tsd_pkg::cum_days(a_mm)};

  assign prev_m   = (a_mm == 4'd1) ? 4'd12 : a_mm - 4'd1;
  assign next_m   = (a_mm == 4'd12) ? 4'd1 : a_mm + 4'd1;
  assign len_cur  = tsd_pkg::month_len(a_mm, leap);
  assign len_prev = tsd_pkg::month_len(prev_m, leap);

  always_comb begin
    stamp_next.day_num = base + {{17{a_dd[5]}}, a_dd};
    stamp_next.tod     = a_tod;
    if (a_dd < 6'sd0) begin
      stamp_next.month = prev_m;
      stamp_next.day   = len_prev;
      stamp_next.year  = (a_mm == 4'd1) ? a_yy - 16'sd1 : a_yy;
    end else if ($unsigned(a_dd) >= {1'b0, len_cur}) begin
      stamp_next.month = next_m;
      stamp_next.day   = a_dd[4:0] - len_cur + 5'd1;
      stamp_next.year  = (a_mm == 4'd12) ? a_yy + 16'sd1 : a_yy;
    end else begin
      stamp_next.month = a_mm;
      stamp_next.day   = a_dd[4:0] + 5'd1;
      stamp_next.year  = a_yy;
    end
  end

  always_ff @(posedge clk) begin
    stamp <= stamp_next;
  end

endmodule

@@ sv/tsd_span.sv @@
module tsd_span (
  input  logic              clk,
  input  logic              rst,
  input  logic              valid_in,
  input  logic [3:0]        cmd_in,
  input  tsd_pkg::stamp_t   stamp_a,
  input  tsd_pkg::stamp_t   stamp_b,
  output logic              valid,
  output tsd_pkg::span_t    span
);

  logic               c_valid;
  logic [3:0]         c_cmd;
  logic signed [23:0] c_days;
  logic signed [17:0] c_secs;
  tsd_pkg::stamp_t    c_a;
  tsd_pkg::stamp_t    c_b;

  logic               neg;
  logic signed [23:0] days_abs;
  logic signed [17:0] secs_abs;
  logic signed [17:0] secs_wrap;
  logic               borrow;
  tsd_pkg::stamp_t    hi;
  tsd_pkg::stamp_t    lo;
  logic signed [16:0] dy;
  logic signed [4:0]  dm;
  logic signed [6:0]  dday;
  tsd_pkg::span_t     span_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else begin
      c_valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    c_cmd  <= cmd_in;
    c_days <= $signed({1'b0, stamp_b.day_num}) - $signed({1'b0, stamp_a.day_num});
    c_secs <= $signed({1'b0, stamp_b.tod}) - $signed({1'b0, stamp_a.tod});
    c_a    <= stamp_a;
    c_b    <= stamp_b;
  end

  assign neg       = (c_days < 24'sd0) || ((c_days == 24'sd0) && (c_secs < 18'sd0));
  assign days_abs  = neg ? -c_days : c_days;
  assign secs_abs  = neg ? -c_secs : c_secs;
  assign borrow    = secs_abs < 18'sd0;
  assign secs_wrap = secs_abs + $signed({1'b0, tsd_pkg::SECS_PER_DAY});
  assign hi        = neg ? c_a : c_b;
  assign lo        = neg ? c_b : c_a;

  // Calendar difference with borrows: time of day, then day, then month.
  always_comb begin
    dy   = $signed({hi.year[15], hi.year}) - $signed({lo.year[15], lo.year});
    dm   = $signed({1'b0, hi.month}) - $signed({1'b0, lo.month});
    dday = $signed({2'b00, hi.day}) - $signed({2'b00, lo.day}) - $signed({6'd0, borrow});
    if (dday < 7'sd0) begin
      dm = dm - 5'sd1;
    end
    if (dm < 5'sd0) begin
      dm = dm + $signed({1'b0, tsd_pkg::MONTHS_PER_YR});
      dy = dy - 17'sd1;
    end
  end

  always_comb begin
    span_next.cmd    = c_cmd;
    span_next.neg    = neg;
    span_next.days   = days_abs[22:0] - {22'd0, borrow};
    span_next.secs   = borrow ? secs_wrap[16:0] : secs_abs[16:0];
    span_next.months = 18'(dy[14:0]) * 18'(tsd_pkg::MONTHS_PER_YR) + {14'd0, dm[3:0]};
    span_next.years  = dy[14:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    span <= span_next;
  end

endmodule

@@ sv/tsd_scale.sv @@
module tsd_scale (
  input  logic              clk,
  input  logic              rst,
  input  logic              valid_in,
  input  tsd_pkg::span_t    span,
  output logic              done,
  output tsd_pkg::result_t  result
);

  logic [35:0] p60;
  logic [33:0] p3600;
  logic [46:0] p7;
  logic [36:0] p3;

  logic        e_valid;
  logic [3:0]  e_cmd;
  logic        e_neg;
  logic [22:0] e_days;
  logic [16:0] e_secs;
  logic [39:0] e_sec_hi;
  logic [33:0] e_min_hi;
  logic [27:0] e_hour_hi;
  logic [10:0] e_q60;
  logic [4:0]  e_q3600;
  logic [20:0] e_week;
  logic [16:0] e_quarter;
  logic [31:0] e_usec;
  logic        e_usec_big;
  logic [17:0] e_months;
  logic [14:0] e_years;

  logic [39:0]      mag;
  logic             neg_eff;
  logic             sat;
  logic [31:0]      val;
  tsd_pkg::result_t result_next;

  assign p60   = 36'(span.secs) * 36'(tsd_pkg::RECIP_60);
  assign p3600 = 34'(span.secs) * 34'(tsd_pkg::RECIP_3600);
  assign p7    = 47'(span.days) * 47'(tsd_pkg::RECIP_7);
  assign p3    = 37'(span.months) * 37'(tsd_pkg::RECIP_3);

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else begin
      e_valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    e_cmd      <= span.cmd;
    e_neg      <= span.neg;
    e_days     <= span.days;
    e_secs     <= span.secs;
    e_sec_hi   <= 40'(span.days) * 40'(tsd_pkg::SECS_PER_DAY);
    e_min_hi   <= 34'(span.days) * 34'd1440;
    e_hour_hi  <= 28'(span.days) * 28'd24;
    e_q60      <= p60[tsd_pkg::SHIFT_60 +: 11];
    e_q3600    <= p3600[tsd_pkg::SHIFT_3600 +: 5];
    e_week     <= p7[tsd_pkg::SHIFT_7 +: 21];
    e_quarter  <= p3[tsd_pkg::SHIFT_3 +: 17];
    e_usec     <= 32'(span.secs[11:0]) * 32'(tsd_pkg::USEC_PER_SEC);
    e_usec_big <= (span.days != 23'd0) || (span.secs > 17'(tsd_pkg::USEC_SEC_MAX));
    e_months   <= span.months;
    e_years    <= span.years;
  end

  always_comb begin
    neg_eff = e_neg;
    unique case (e_cmd)
      tsd_pkg::CMD_USEC:    mag = e_usec_big ? '1 : 40'(e_usec);
      tsd_pkg::CMD_SEC:     mag = e_sec_hi + 40'(e_secs);
      tsd_pkg::CMD_MIN:     mag = 40'(e_min_hi) + 40'(e_q60);
      tsd_pkg::CMD_HOUR:    mag = 40'(e_hour_hi) + 40'(e_q3600);
      tsd_pkg::CMD_DAY:     mag = 40'(e_days);
      tsd_pkg::CMD_WEEK:    mag = 40'(e_week);
      tsd_pkg::CMD_MONTH:   mag = 40'(e_months);
      tsd_pkg::CMD_QUARTER: mag = 40'(e_quarter);
      tsd_pkg::CMD_YEAR:    mag = 40'(e_years);
      default: begin
        mag     = 40'd0;
        neg_eff = 1'b0;
      end
    endcase
  end

  always_comb begin
    if (neg_eff) begin
      sat = mag > 40'h80000000;
      val = sat ? 32'h80000000 : -mag[31:0];
    end else begin
      sat = mag > 40'h7FFFFFFF;
      val = sat ? 32'h7FFFFFFF : mag[31:0];
    end
    result_next.difference = $signed(val);
    result_next.saturated  = sat;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= e_valid;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

endmodule
